[hdl/stf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Statistical TDM framer package
// Shared payload types, command codes, queue status and sequencer states.
// ----------------------------------------------------------------------------
package stf_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 64;
   localparam int MAX_SLOTS_DEFAULT   = 16;

   // frame length field holds up to the largest allowed slot count
   localparam int FRAME_LEN_W    = 7;
   localparam int CSR_W          = 5;
   localparam int CMD_FIFO_DEPTH = 2;

   localparam logic CMD_ARRIVAL = 1'b0;
   localparam logic CMD_TICK    = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [3:0]  channel;
      logic [31:0] payload;
   } req_type;

   typedef struct packed {
      logic [3:0]  out_channel;
      logic [31:0] out_payload;
      logic [15:0] time_unit;
      logic [3:0]  slot_index;
      logic        last_in_frame;
      logic        overflow;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  channel;
      logic [31:0] payload;
   } entry_type;

   typedef struct packed {
      logic [15:0]            time_unit;
      logic                   overflow;
      logic [FRAME_LEN_W-1:0] length;
   } frame_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_RUN
   } back_state_type;

endpackage

[hdl/stf_data_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subframe buffer
// Circular memory of queued arrivals, one write and one registered read port.
// ----------------------------------------------------------------------------
module stf_data_buf #(
   parameter int QUEUE_DEPTH = stf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  stf_pkg::entry_type       wr_entry,
   input  logic                     rd_en,
   output stf_pkg::entry_type       rd_entry,
   output stf_pkg::queue_status_type status
);

   localparam int AddrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
   localparam logic [AddrW-1:0] LastAddr = AddrW'(QUEUE_DEPTH - 1);

   stf_pkg::entry_type store_ff [QUEUE_DEPTH];
   stf_pkg::entry_type rd_entry_ff;
   logic [AddrW-1:0] head_ff, head_in;
   logic [AddrW-1:0] tail_ff, tail_in;
   logic [CntW-1:0]  count_ff, count_in;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (wr_en) begin
         tail_in = (tail_ff == LastAddr) ? '0 : tail_ff + 1'b1;
      end
      if (rd_en) begin
         head_in = (head_ff == LastAddr) ? '0 : head_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[tail_ff] <= wr_entry;
      end
      if (rd_en) begin
         rd_entry_ff <= store_ff[head_ff];
      end
   end

   assign rd_entry     = rd_entry_ff;
   assign status.full  = (count_ff == CntW'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

[hdl/stf_cmd_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame command queue
// Short queue of frame commands between the front and the back end.
// ----------------------------------------------------------------------------
module stf_cmd_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  stf_pkg::frame_cmd_type    push_data,
   input  logic                      pop,
   output stf_pkg::frame_cmd_type    pop_data,
   output stf_pkg::queue_status_type status
);

   localparam int Depth = stf_pkg::CMD_FIFO_DEPTH;
   localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW  = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

   stf_pkg::frame_cmd_type slot_ff [Depth];
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CntW'(Depth));
   assign status.empty = (count_ff == '0);

endmodule

[hdl/stf_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framer front end
// Takes arrivals and ticks, keeps queue occupancy, time unit and overflow,
// and issues one frame command per non-empty tick.
// ----------------------------------------------------------------------------
module stf_front #(
   parameter int QUEUE_DEPTH = stf_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int MAX_SLOTS   = stf_pkg::MAX_SLOTS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  stf_pkg::req_type          req_data,
   input  logic                      csr_wr_en,
   input  logic [stf_pkg::CSR_W-1:0] csr_wr_data,
   input  stf_pkg::queue_status_type buf_status,
   output logic                      buf_wr_en,
   output stf_pkg::entry_type        buf_wr_entry,
   input  stf_pkg::queue_status_type cmd_status,
   output logic                      cmd_push,
   output stf_pkg::frame_cmd_type    cmd_data
);

   localparam int CntW = $clog2(QUEUE_DEPTH + 1);
   localparam int LenW = stf_pkg::FRAME_LEN_W;

   logic [stf_pkg::CSR_W-1:0] spf_ff;
   logic [CntW-1:0]           count_ff, count_in;
   logic [15:0]               time_ff, time_in;
   logic                      ovf_ff, ovf_in;
   logic [LenW-1:0]           limit;
   logic [LenW-1:0]           frame_len;
   logic                      logic_full;
   logic                      is_tick;
   logic                      accept;

   assign is_tick    = (req_data.cmd == stf_pkg::CMD_TICK);
   assign logic_full = (count_ff == CntW'(QUEUE_DEPTH));

   always_comb begin
      priority if (spf_ff == '0) begin
         limit = LenW'(1);
      end else if (32'(spf_ff) > 32'(MAX_SLOTS)) begin
         limit = LenW'(MAX_SLOTS);
      end else begin
         limit = LenW'(spf_ff);
      end
      frame_len = (32'(count_ff) < 32'(limit)) ? LenW'(count_ff) : limit;
   end

   always_comb begin
      if (is_tick) begin
         req_ready = (frame_len == '0) || !cmd_status.full;
      end else begin
         req_ready = logic_full || !buf_status.full;
      end
   end

   assign accept = req_valid && req_ready;

   always_comb begin
      count_in  = count_ff;
      time_in   = time_ff;
      ovf_in    = ovf_ff;
      buf_wr_en = 1'b0;
      cmd_push  = 1'b0;
      if (accept) begin
         if (is_tick) begin
            cmd_push = (frame_len != '0);
            count_in = count_ff - CntW'(frame_len);
            time_in  = time_ff + 16'd1;
         end else if (logic_full) begin
            ovf_in = 1'b1;
         end else begin
            buf_wr_en = 1'b1;
            count_in  = count_ff + 1'b1;
         end
      end
   end

   assign buf_wr_entry.channel = req_data.channel;
   assign buf_wr_entry.payload = req_data.payload;
   assign cmd_data.time_unit   = time_ff;
   assign cmd_data.overflow    = ovf_ff;
   assign cmd_data.length      = frame_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         spf_ff   <= stf_pkg::CSR_W'(1);
         count_ff <= '0;
         time_ff  <= 16'd1;
         ovf_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            spf_ff <= csr_wr_data;
         end
         count_ff <= count_in;
         time_ff  <= time_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

[hdl/stf_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framer back end
// Takes frame commands and reads the queued subframes out one by one into
// the result register.
// ----------------------------------------------------------------------------
module stf_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   output logic                   cmd_pop,
   input  stf_pkg::frame_cmd_type cmd_data,
   output logic                   buf_rd_en,
   input  stf_pkg::entry_type     buf_rd_entry,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output stf_pkg::rsp_type       rsp_data
);

   localparam int LenW = stf_pkg::FRAME_LEN_W;

   stf_pkg::back_state_type state_ff, state_in;
   logic [LenW-1:0]  len_ff;
   logic [LenW-1:0]  slot_ff;
   logic [15:0]      time_ff;
   logic             ovf_ff;
   logic             pend_ff;
   logic [LenW-1:0]  pend_slot_ff;
   logic             pend_last_ff;
   logic             rsp_valid_ff;
   stf_pkg::rsp_type rsp_data_ff;
   logic             last_issue;

   assign last_issue = (slot_ff == len_ff - 1'b1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         stf_pkg::BACK_IDLE: begin
            if (cmd_valid) begin
               state_in = stf_pkg::BACK_RUN;
            end
         end
         stf_pkg::BACK_RUN: begin
            if (buf_rd_en && last_issue) begin
               state_in = stf_pkg::BACK_IDLE;
            end
         end
         default: state_in = stf_pkg::BACK_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop   = 1'b0;
      buf_rd_en = 1'b0;
      unique case (state_ff)
         stf_pkg::BACK_IDLE: cmd_pop = cmd_valid;
         stf_pkg::BACK_RUN:  buf_rd_en = !pend_ff && (!rsp_valid_ff || rsp_ready);
         default: begin
            cmd_pop   = 1'b0;
            buf_rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stf_pkg::BACK_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= buf_rd_en;
         if (pend_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         len_ff  <= cmd_data.length;
         time_ff <= cmd_data.time_unit;
         ovf_ff  <= cmd_data.overflow;
         slot_ff <= '0;
      end else if (buf_rd_en) begin
         slot_ff <= slot_ff + 1'b1;
      end
      if (buf_rd_en) begin
         pend_slot_ff <= slot_ff;
         pend_last_ff <= last_issue;
      end
      if (pend_ff) begin
         rsp_data_ff.out_channel   <= buf_rd_entry.channel;
         rsp_data_ff.out_payload   <= buf_rd_entry.payload;
         rsp_data_ff.time_unit     <= time_ff;
         rsp_data_ff.slot_index    <= 4'(pend_slot_ff);
         rsp_data_ff.last_in_frame <= pend_last_ff;
         rsp_data_ff.overflow      <= ovf_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hdl/statistical_tdm_framer_core.sv]
`timescale 1ns / 1ps
// Arrivals: one transfer per cycle while the subframe buffer has room; once the
// queue count is full they are taken and dropped, setting overflow. Ticks: one
// per cycle while the command queue has room or the frame is empty; a frame is
// read out one subframe at a time, held off by the buffer's registered read port.
// Reset is synchronous: control state clears at once, buffer contents are kept.
// ----------------------------------------------------------------------------
// Statistical TDM framer core
// Shared-queue multiplexer that packs queued subframes into one frame per tick.
// ----------------------------------------------------------------------------
module statistical_tdm_framer_core #(
   parameter int QUEUE_DEPTH = stf_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int MAX_SLOTS   = stf_pkg::MAX_SLOTS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  stf_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output stf_pkg::rsp_type          rsp_data,
   input  logic                      csr_wr_en,
   input  logic [stf_pkg::CSR_W-1:0] csr_wr_data
);

   stf_pkg::queue_status_type buf_status;
   stf_pkg::queue_status_type cmd_status;
   stf_pkg::entry_type        buf_wr_entry;
   stf_pkg::entry_type        buf_rd_entry;
   stf_pkg::frame_cmd_type    cmd_push_data;
   stf_pkg::frame_cmd_type    cmd_pop_data;
   logic                      buf_wr_en;
   logic                      buf_rd_en;
   logic                      cmd_push;
   logic                      cmd_pop;

   stf_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .MAX_SLOTS   (MAX_SLOTS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .buf_status   (buf_status),
      .buf_wr_en    (buf_wr_en),
      .buf_wr_entry (buf_wr_entry),
      .cmd_status   (cmd_status),
      .cmd_push     (cmd_push),
      .cmd_data     (cmd_push_data)
   );

   stf_data_buf #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_data_buf (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (buf_wr_en),
      .wr_entry (buf_wr_entry),
      .rd_en    (buf_rd_en),
      .rd_entry (buf_rd_entry),
      .status   (buf_status)
   );

   stf_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_push_data),
      .pop       (cmd_pop),
      .pop_data  (cmd_pop_data),
      .status    (cmd_status)
   );

   stf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (!cmd_status.empty),
      .cmd_pop      (cmd_pop),
      .cmd_data     (cmd_pop_data),
      .buf_rd_en    (buf_rd_en),
      .buf_rd_entry (buf_rd_entry),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

   a_no_read_empty: assert property (@(posedge clock) disable iff (reset)
      buf_rd_en |-> !buf_status.empty)
      else $error("subframe read from empty buffer");

   a_no_write_full: assert property (@(posedge clock) disable iff (reset)
      buf_wr_en |-> !buf_status.full)
      else $error("subframe written to full buffer");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> (!cmd_status.full && cmd_push_data.length != '0))
      else $error("bad frame command push");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

[tb/tb_statistical_tdm_framer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Statistical TDM framer core testbench
// Sends arrivals and ticks through the request channel with random gaps and
// checks every subframe on the response channel against a cycle-free model of
// the shared queue, the slot limit, the time counter and the overflow flag.
// Covers slot limit extremes, queue overflow and back-pressure.
// ----------------------------------------------------------------------------
module tb_statistical_tdm_framer_core;

   localparam int FIFO_SLOTS    = 64;
   localparam int SLOT_CAP      = 16;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 200;
   localparam int STALL_LIMIT   = 4000;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_ready;
   stf_pkg::req_type          req_data    = '0;
   logic                      rsp_valid;
   logic                      rsp_ready   = 1'b0;
   stf_pkg::rsp_type          rsp_data;
   logic                      csr_wr_en   = 1'b0;
   logic [stf_pkg::CSR_W-1:0] csr_wr_data = '0;

   stf_pkg::req_type   cmds_to_send[$];
   stf_pkg::rsp_type   subframes_due[$];
   stf_pkg::entry_type fifo_mem[FIFO_SLOTS];
   int        fifo_fill;
   int        fifo_rd;
   int        fifo_wr;
   logic [15:0] tu_counter;
   logic        drop_seen;
   logic [4:0]  slot_limit_reg;

   int   subframe_errors = 0;
   logic req_xfer = 1'b0;
   logic rsp_xfer = 1'b0;
   int   req_gap = 0;
   int   req_run = 0;
   int   rsp_gap = 0;
   int   rsp_run = 0;
   logic hold_req = 1'b0;
   logic hold_ack = 1'b0;
   int   hold_left = 0;
   int   quiet_cycles = 0;

   statistical_tdm_framer_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int pick_gap(inout int run);
      int g;
      if (run > 0) begin
         run--;
         g = 0;
      end else begin
         if ($urandom_range(0, 15) == 0) run = $urandom_range(8, 24);
         g = $urandom_range(0, 3);
      end
      return g;
   endfunction

   function automatic void framer_step(stf_pkg::req_type item);
      int               lim;
      int               k;
      stf_pkg::rsp_type sub;
      if (item.cmd == stf_pkg::CMD_ARRIVAL) begin
         if (fifo_fill >= FIFO_SLOTS) begin
            drop_seen = 1'b1;
         end else begin
            fifo_mem[fifo_wr] = {item.channel, item.payload};
            fifo_wr = (fifo_wr + 1) % FIFO_SLOTS;
            fifo_fill++;
         end
      end else begin
         lim = int'(slot_limit_reg);
         if (lim == 0) lim = 1;
         if (lim > SLOT_CAP) lim = SLOT_CAP;
         for (k = 0; k < lim && fifo_fill > 0; k++) begin
            sub.out_channel = fifo_mem[fifo_rd].channel;
            sub.out_payload = fifo_mem[fifo_rd].payload;
            fifo_rd = (fifo_rd + 1) % FIFO_SLOTS;
            fifo_fill--;
            sub.time_unit     = tu_counter;
            sub.slot_index    = k[3:0];
            sub.last_in_frame = (k + 1 == lim) || (fifo_fill == 0);
            sub.overflow      = drop_seen;
            subframes_due.insert(subframes_due.size(), sub);
         end
         tu_counter = tu_counter + 16'd1;
      end
   endfunction

   task automatic check_subframe(stf_pkg::rsp_type got);
      stf_pkg::rsp_type want;
      if (subframes_due.size() == 0) begin
         subframe_errors++;
         if (subframe_errors <= 10)
            $display("%0t: unexpected subframe %h", $time, got);
      end else begin
         want = subframes_due.pop_front();
         if (got.out_channel !== want.out_channel || got.out_payload !== want.out_payload ||
             got.time_unit !== want.time_unit || got.slot_index !== want.slot_index ||
             got.last_in_frame !== want.last_in_frame || got.overflow !== want.overflow) begin
            subframe_errors++;
            if (subframe_errors <= 10)
               $display("%0t: subframe mismatch exp ch %0d data %h tu %0d slot %0d last %b ovf %b",
                        $time, want.out_channel, want.out_payload, want.time_unit,
                        want.slot_index, want.last_in_frame, want.overflow);
            if (subframe_errors <= 10)
               $display("%0t:                   got ch %0d data %h tu %0d slot %0d last %b ovf %b",
                        $time, got.out_channel, got.out_payload, got.time_unit,
                        got.slot_index, got.last_in_frame, got.overflow);
         end
      end
   endtask

   // request side: model the transfer, then drive the next item
   always @(posedge clock) begin
      if (reset) begin
         req_xfer <= 1'b0;
      end else begin
         req_xfer <= req_valid && req_ready;
         if (req_valid && req_ready) framer_step(req_data);
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else if (!req_valid || req_xfer) begin
         if (req_gap != 0) begin
            req_valid <= 1'b0;
            req_gap   <= req_gap - 1;
         end else if (cmds_to_send.size() != 0) begin
            req_data  <= cmds_to_send.pop_front();
            req_valid <= 1'b1;
            req_gap   <= pick_gap(req_run);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response side
   always @(posedge clock) begin
      if (reset) begin
         rsp_xfer <= 1'b0;
      end else begin
         rsp_xfer <= rsp_valid && rsp_ready;
         if (rsp_valid && rsp_ready) check_subframe(rsp_data);
      end
   end

   always @(negedge clock) begin : rsp_ready_drive
      int g;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap   <= 0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
      end else if (rsp_xfer) begin
         g = pick_gap(rsp_run);
         if (g == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            rsp_gap   <= g - 1;
         end
      end else if (rsp_gap != 0) begin
         rsp_ready <= 1'b0;
         rsp_gap   <= rsp_gap - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // long receiver hold-off, counted here
   always @(negedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_ack  <= hold_req;
      end else if (hold_req != hold_ack) begin
         hold_left <= HOLD_CYCLES;
         hold_ack  <= hold_req;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (cmds_to_send.size() == 0 && !req_valid && subframes_due.size() == 0)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic add_arrival(logic [3:0] ch, logic [31:0] data);
      stf_pkg::req_type item;
      item.cmd     = stf_pkg::CMD_ARRIVAL;
      item.channel = ch;
      item.payload = data;
      cmds_to_send.insert(cmds_to_send.size(), item);
   endtask

   task automatic add_tick();
      stf_pkg::req_type item;
      item.cmd     = stf_pkg::CMD_TICK;
      item.channel = 4'($urandom_range(0, 15));
      item.payload = $urandom;
      cmds_to_send.insert(cmds_to_send.size(), item);
   endtask

   task automatic add_random_traffic(int n, int tick_pct);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < tick_pct) add_tick();
         else add_arrival(4'($urandom_range(0, 15)), $urandom);
      end
   endtask

   task automatic wait_drained();
      while (cmds_to_send.size() != 0 || req_valid || subframes_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_slots(logic [4:0] v);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      slot_limit_reg = v;
   endtask

   initial begin : stimulus
      int n;
      fifo_fill      = 0;
      fifo_rd        = 0;
      fifo_wr        = 0;
      tu_counter     = 16'd1;
      drop_seen      = 1'b0;
      slot_limit_reg = 5'd1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, frame ended by emptiness, empty tick, limit
      set_slots(5'd4);
      add_arrival(4'd0, 32'h0000_0000);
      add_arrival(4'd15, 32'hFFFF_FFFF);
      add_arrival(4'd10, 32'h5555_5555);
      add_arrival(4'd5, 32'hAAAA_AAAA);
      add_tick();
      add_tick();
      for (int i = 1; i <= 6; i++) add_arrival(i[3:0], $urandom);
      add_tick();
      add_tick();
      wait_drained();
      set_slots(5'd1);
      add_arrival(4'd3, $urandom);
      add_arrival(4'd12, $urandom);
      add_tick();
      add_tick();
      wait_drained();

      set_slots(5'd31);
      add_random_traffic(10, 25);
      wait_drained();

      // stall the receiver while requests keep coming
      set_slots(5'd2);
      @(posedge clock);
      hold_req = ~hold_req;
      repeat (8) add_arrival(4'($urandom_range(0, 15)), $urandom);
      repeat (6) add_tick();
      add_random_traffic(10, 40);
      wait_drained();

      // overrun the shared queue by two arrivals, then drain it
      set_slots(5'd16);
      n = FIFO_SLOTS - fifo_fill + 2;
      for (int i = 0; i < n; i++) add_arrival(4'($urandom_range(0, 15)), $urandom);
      repeat (5) add_tick();
      wait_drained();

      set_slots(5'd0);
      add_random_traffic(6, 30);
      wait_drained();

      if (subframe_errors == 0 && subframes_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/stf_pkg.sv
hdl/stf_data_buf.sv
hdl/stf_cmd_fifo.sv
hdl/stf_front.sv
hdl/stf_back.sv
hdl/statistical_tdm_framer_core.sv
tb/tb_statistical_tdm_framer_core.sv
